[hdl/attu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attu_pkg
// Sizes, codes and word types shared by the transition table unit.
// ----------------------------------------------------------------------------
package attu_pkg;

  localparam int STATE_SLOTS    = 32;
  localparam int ALPHABET_MAX   = 16;
  localparam int TRANS_PER_PAIR = 4;
  localparam int MAX_RETURN     = 16;

  localparam int PAIR_TOTAL  = STATE_SLOTS * ALPHABET_MAX;
  localparam int TRANS_TOTAL = PAIR_TOTAL * TRANS_PER_PAIR;

  localparam int SID_W   = $clog2(STATE_SLOTS);
  localparam int CNT_W   = $clog2(STATE_SLOTS + 1);
  localparam int PAIR_W  = $clog2(PAIR_TOTAL);
  localparam int TADDR_W = $clog2(TRANS_TOTAL);
  localparam int TID_W   = $clog2(TRANS_TOTAL + 1);
  localparam int MRC_W   = $clog2(MAX_RETURN + 1);
  localparam int AU_W    = $clog2(ALPHABET_MAX + 1);

  // end-of-chain marker
  localparam logic [TID_W-1:0] TID_END = TID_W'(TRANS_TOTAL);

  localparam logic [2:0] CMD_CLEAR      = 3'd0;
  localparam logic [2:0] CMD_ADD_STATE  = 3'd1;
  localparam logic [2:0] CMD_SET_INIT   = 3'd2;
  localparam logic [2:0] CMD_ADD_TRANS  = 3'd3;
  localparam logic [2:0] CMD_SUCC       = 3'd4;
  localparam logic [2:0] CMD_ACCEPT     = 3'd5;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_ADD_STATE,
    OP_SET_INIT,
    OP_ADD_TRANS,
    OP_SUCC,
    OP_ACCEPT,
    OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_HEAD,
    B_VERIFY,
    B_WALK
  } bstate_t;

  // decoded command word, front to back
  typedef struct packed {
    op_t               op;
    logic              init;
    logic              acc;
    logic [4:0]        sid;
    logic [4:0]        src;
    logic [4:0]        dst;
    logic [MRC_W-1:0]  maxc;
    logic              sym_ok;
    logic [PAIR_W-1:0] pair;
  } work_t;

  // one result word
  typedef struct packed {
    logic       status;
    logic [4:0] state;
    logic       acc;
    logic       last;
  } res_t;

  // transition entry: owning pair, older link, destination
  typedef struct packed {
    logic [PAIR_W-1:0] pair;
    logic [TID_W-1:0]  link;
    logic [4:0]        dest;
  } tent_t;

  localparam res_t RES_FAIL = '{status: 1'b1, state: 5'd0, acc: 1'b0, last: 1'b1};
  localparam res_t RES_OK   = '{status: 1'b0, state: 5'd0, acc: 1'b0, last: 1'b1};

endpackage

[hdl/attu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attu_front
// Holds the alphabet register, decodes commands and queues them for the back.
// ----------------------------------------------------------------------------
module attu_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         command,
  input  logic               mark_initial,
  input  logic               mark_accepting,
  input  logic [4:0]         query_id,
  input  logic [4:0]         source_state,
  input  logic [3:0]         symbol,
  input  logic [4:0]         dest_state,
  input  logic [4:0]         max_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data,
  output attu_pkg::work_t    work_item,
  output logic               work_valid,
  input  logic               work_pop
);
  import attu_pkg::*;

  logic [AU_W-1:0] alphabet_used;
  work_t           dec;
  work_t           q_mem [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      cnt;
  logic            wr_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_used <= AU_W'(ALPHABET_MAX);
    end else if (cfg_valid) begin
      alphabet_used <= (int'(cfg_data) > ALPHABET_MAX) ? AU_W'(ALPHABET_MAX)
                                                       : AU_W'(cfg_data);
    end
  end

  always_comb begin
    dec.init   = mark_initial;
    dec.acc    = mark_accepting;
    dec.sid    = query_id;
    dec.src    = source_state;
    dec.dst    = dest_state;
    dec.maxc   = (int'(max_count) > MAX_RETURN) ? MRC_W'(MAX_RETURN) : MRC_W'(max_count);
    dec.sym_ok = (int'(symbol) < int'(alphabet_used)) && (int'(symbol) < ALPHABET_MAX);
    dec.pair   = PAIR_W'(int'(source_state) * ALPHABET_MAX + int'(symbol));
    case (command)
      CMD_CLEAR:     dec.op = OP_CLEAR;
      CMD_ADD_STATE: dec.op = OP_ADD_STATE;
      CMD_SET_INIT:  dec.op = OP_SET_INIT;
      CMD_ADD_TRANS: dec.op = OP_ADD_TRANS;
      CMD_SUCC:      dec.op = OP_SUCC;
      CMD_ACCEPT:    dec.op = OP_ACCEPT;
      default:       dec.op = OP_BAD;
    endcase
  end

  // two-entry command queue
  assign full       = (cnt == 2'd2);
  assign wr_en      = push && !full;
  assign work_valid = (cnt != 2'd0);
  assign work_item  = q_mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem[wptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (wr_en) wptr <= !wptr;
      if (work_pop) rptr <= !rptr;
      cnt <= cnt + 2'(wr_en) - 2'(work_pop);
    end
  end

endmodule

[hdl/attu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attu_back
// Executes table commands against the state, head and transition stores,
// walks successor chains and queues the result words.
// ----------------------------------------------------------------------------
module attu_back (
  input  logic            clk,
  input  logic            rst,
  input  attu_pkg::work_t work_item,
  input  logic            work_valid,
  output logic            work_pop,
  input  logic            pop,
  output logic            empty,
  output attu_pkg::res_t  res_out
);
  import attu_pkg::*;

  bstate_t            state, state_next;
  logic [CNT_W-1:0]   state_count, state_count_next;
  logic               start_valid, start_valid_next;
  logic [SID_W-1:0]   start_state, start_state_next;
  logic [TID_W-1:0]   tcount, tcount_next;
  work_t              cur, cur_next;
  logic               first, first_next;
  logic [MRC_W-1:0]   n, n_next;

  logic [1:0]         marks [STATE_SLOTS];
  logic               marks_we;
  logic [SID_W-1:0]   marks_waddr;
  logic [1:0]         marks_wdata;
  logic [1:0]         sid_marks;

  logic [TID_W-1:0]   heads [PAIR_TOTAL];
  logic               head_ren, head_we;
  logic [PAIR_W-1:0]  head_raddr, head_waddr;
  logic [TID_W-1:0]   head_q, head_wdata;

  tent_t              trans [TRANS_TOTAL];
  logic               tr_ren, tr_we;
  logic [TADDR_W-1:0] tr_raddr, tr_waddr;
  tent_t              tr_q, tr_wdata;

  logic               add_go;
  logic [TID_W-1:0]   add_link;
  logic               walk_last;

  logic               src_ok, dst_ok, sid_ok, tr_ok, sq_ok;

  res_t               r_mem [2];
  logic               r_wptr, r_rptr;
  logic [1:0]         r_cnt;
  logic               res_wr, res_rd, res_full;
  res_t               res_din;

  assign src_ok = (int'(work_item.src) < int'(state_count)) &&
                  (int'(work_item.src) < STATE_SLOTS);
  assign dst_ok = int'(work_item.dst) < int'(state_count);
  assign sid_ok = (int'(work_item.sid) < int'(state_count)) &&
                  (int'(work_item.sid) < STATE_SLOTS);
  assign tr_ok  = src_ok && dst_ok && work_item.sym_ok && (int'(tcount) < TRANS_TOTAL);
  assign sq_ok  = src_ok && work_item.sym_ok && (work_item.maxc != '0);
  assign sid_marks = marks[SID_W'(work_item.sid)];

  always_comb begin
    state_next       = state;
    state_count_next = state_count;
    start_valid_next = start_valid;
    start_state_next = start_state;
    tcount_next      = tcount;
    cur_next         = cur;
    first_next       = first;
    n_next           = n;
    work_pop         = 1'b0;
    marks_we         = 1'b0;
    marks_waddr      = SID_W'(work_item.sid);
    marks_wdata      = sid_marks;
    head_ren         = 1'b0;
    head_raddr       = work_item.pair;
    tr_ren           = 1'b0;
    tr_raddr         = head_q[TADDR_W-1:0];
    add_go           = 1'b0;
    add_link         = TID_END;
    walk_last        = 1'b0;
    res_wr           = 1'b0;
    res_din          = RES_FAIL;

    case (state)
      B_IDLE: begin
        if (work_valid) begin
          if ((work_item.op == OP_ADD_TRANS && tr_ok) ||
              (work_item.op == OP_SUCC && sq_ok)) begin
            work_pop   = 1'b1;
            cur_next   = work_item;
            head_ren   = 1'b1;
            n_next     = '0;
            state_next = B_HEAD;
          end else if (!res_full) begin
            work_pop = 1'b1;
            res_wr   = 1'b1;
            case (work_item.op)
              OP_CLEAR: begin
                state_count_next = '0;
                start_valid_next = 1'b0;
                start_state_next = '0;
                tcount_next      = '0;
                res_din          = RES_OK;
              end
              OP_ADD_STATE: begin
                if (int'(state_count) < STATE_SLOTS) begin
                  marks_we         = 1'b1;
                  marks_waddr      = state_count[SID_W-1:0];
                  marks_wdata      = {work_item.acc, work_item.init};
                  state_count_next = state_count + CNT_W'(1);
                  if (work_item.init && !start_valid) begin
                    start_valid_next = 1'b1;
                    start_state_next = state_count[SID_W-1:0];
                  end
                  res_din       = RES_OK;
                  res_din.state = 5'(state_count);
                end
              end
              OP_SET_INIT: begin
                if (sid_ok) begin
                  start_valid_next = 1'b1;
                  start_state_next = SID_W'(work_item.sid);
                  marks_we         = 1'b1;
                  marks_wdata      = sid_marks | 2'b01;
                  res_din          = RES_OK;
                end
              end
              OP_ACCEPT: begin
                if (sid_ok) begin
                  res_din     = RES_OK;
                  res_din.acc = sid_marks[1];
                end
              end
              default: res_din = RES_FAIL;
            endcase
          end
        end
      end

      B_HEAD: begin
        // a head is live only if it names a transition added since the
        // last clear that belongs to this pair; the pair check is next
        if (head_q < tcount) begin
          tr_ren     = 1'b1;
          first_next = 1'b1;
          state_next = (cur.op == OP_ADD_TRANS) ? B_VERIFY : B_WALK;
        end else if (!res_full) begin
          if (cur.op == OP_ADD_TRANS) begin
            add_go = 1'b1;
          end else begin
            res_wr = 1'b1;
          end
          state_next = B_IDLE;
        end
      end

      B_VERIFY: begin
        if (!res_full) begin
          add_go = 1'b1;
          if (tr_q.pair == cur.pair) begin
            add_link = head_q;
          end
          state_next = B_IDLE;
        end
      end

      B_WALK: begin
        if (!res_full) begin
          res_wr = 1'b1;
          if (first && (tr_q.pair != cur.pair)) begin
            state_next = B_IDLE;
          end else begin
            walk_last     = (tr_q.link >= tcount) || ((n + MRC_W'(1)) == cur.maxc);
            res_din       = RES_OK;
            res_din.state = tr_q.dest;
            res_din.last  = walk_last;
            n_next        = n + MRC_W'(1);
            first_next    = 1'b0;
            if (walk_last) begin
              state_next = B_IDLE;
            end else begin
              tr_ren   = 1'b1;
              tr_raddr = tr_q.link[TADDR_W-1:0];
            end
          end
        end
      end

      default: state_next = B_IDLE;
    endcase

    // push onto the chain of the current pair
    tr_we      = add_go;
    tr_waddr   = tcount[TADDR_W-1:0];
    tr_wdata   = '{pair: cur.pair, link: add_link, dest: cur.dst};
    head_we    = add_go;
    head_waddr = cur.pair;
    head_wdata = tcount;
    if (add_go) begin
      tcount_next = tcount + TID_W'(1);
      res_wr      = 1'b1;
      res_din     = RES_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      state_count <= '0;
      start_valid <= 1'b0;
      start_state <= '0;
      tcount      <= '0;
      first       <= 1'b0;
      n           <= '0;
    end else begin
      state       <= state_next;
      state_count <= state_count_next;
      start_valid <= start_valid_next;
      start_state <= start_state_next;
      tcount      <= tcount_next;
      first       <= first_next;
      n           <= n_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (marks_we) marks[marks_waddr] <= marks_wdata;
  end

  always_ff @(posedge clk) begin
    if (head_we) heads[head_waddr] <= head_wdata;
    if (head_ren) head_q <= heads[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (tr_we) trans[tr_waddr] <= tr_wdata;
    if (tr_ren) tr_q <= trans[tr_raddr];
  end

  // two-entry result queue
  assign res_full = (r_cnt == 2'd2);
  assign empty    = (r_cnt == 2'd0);
  assign res_rd   = pop && !empty;
  assign res_out  = r_mem[r_rptr];

  always_ff @(posedge clk) begin
    if (res_wr) r_mem[r_wptr] <= res_din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_wptr <= 1'b0;
      r_rptr <= 1'b0;
      r_cnt  <= 2'd0;
    end else begin
      if (res_wr) r_wptr <= !r_wptr;
      if (res_rd) r_rptr <= !r_rptr;
      r_cnt <= r_cnt + 2'(res_wr) - 2'(res_rd);
    end
  end

endmodule

[hdl/automaton_transition_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// automaton_transition_table_unit
// Command-driven transition table of a nondeterministic automaton.
// ----------------------------------------------------------------------------
// Throughput: one-step commands retire 1 per cycle while the result queue has
//   room; add transition reads the chain head, and verifies it on a non-empty
//   chain, before it writes; a successor query reads the head, then walks the chain.
// Reset: synchronous; the unit takes words in the first cycle after reset.
//   The chain heads need no clearing pass (see the head check below).
// ----------------------------------------------------------------------------
//
// Structure
//   front : alphabet register, command decode, 2-word command queue
//   back  : executor with the state marks, the chain head memory
//           (one per source/symbol pair) and the transition memory, plus a
//           2-word result queue feeding the output ports
//
// Chain heads are never swept. A head is trusted only when it points at a
// transition below the current count whose stored pair matches; a stale head
// from before a clear can't meet both, since reusing that slot for the same
// pair would have rewritten the head. Links are checked when written, so the
// walk past the first entry needs no check.
module automaton_transition_table_unit (
  input  logic       clk,
  input  logic       rst,
  // command side
  input  logic       push,
  output logic       full,
  input  logic [2:0] command,
  input  logic       mark_initial,
  input  logic       mark_accepting,
  input  logic [4:0] query_id,
  input  logic [4:0] source_state,
  input  logic [3:0] symbol,
  input  logic [4:0] dest_state,
  input  logic [4:0] max_count,
  // result side
  output logic       empty,
  input  logic       pop,
  output logic       status,
  output logic [4:0] result_state,
  output logic       accept_mark,
  output logic       last,
  // alphabet register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);
  import attu_pkg::*;

  work_t work_item;
  logic  work_valid;
  logic  work_pop;
  res_t  res_out;

  attu_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .command        (command),
    .mark_initial   (mark_initial),
    .mark_accepting (mark_accepting),
    .query_id       (query_id),
    .source_state   (source_state),
    .symbol         (symbol),
    .dest_state     (dest_state),
    .max_count      (max_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .work_item      (work_item),
    .work_valid     (work_valid),
    .work_pop       (work_pop)
  );

  attu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work_item  (work_item),
    .work_valid (work_valid),
    .work_pop   (work_pop),
    .pop        (pop),
    .empty      (empty),
    .res_out    (res_out)
  );

  // result word out to the ports
  assign status       = res_out.status;
  assign result_state = res_out.state;
  assign accept_mark  = res_out.acc;
  assign last         = res_out.last;

endmodule

[hdl/attu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attu_props
// Port-level checks for the transition table unit, bound to the top level.
// ----------------------------------------------------------------------------
module attu_props (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       status,
  input logic [4:0] result_state,
  input logic       accept_mark,
  input logic       last
);

  // the result queue comes out of reset empty and the command queue not full
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // a waiting word holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(result_state) &&
                          $stable(accept_mark) && $stable(last)))
    else $error("result word changed while stalled");

  // a rejection or a miss always closes its command
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> last)
    else $error("failing result without last");

  // an accepting mark only comes from a successful accepting query
  a_acc_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && accept_mark) |-> (!status && result_state == 5'd0 && last))
    else $error("accepting mark on a wrong result");

endmodule

bind automaton_transition_table_unit attu_props u_attu_props (.*);

[test/attu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attu_checker
// Watches the command, result and alphabet channels of the transition table
// unit, keeps its own copy of the table, and compares every result word.
// ----------------------------------------------------------------------------
module attu_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [2:0] command,
  input  logic       mark_initial,
  input  logic       mark_accepting,
  input  logic [4:0] query_id,
  input  logic [4:0] source_state,
  input  logic [3:0] symbol,
  input  logic [4:0] dest_state,
  input  logic [4:0] max_count,
  input  logic       empty,
  input  logic       pop,
  input  logic       status,
  input  logic [4:0] result_state,
  input  logic       accept_mark,
  input  logic       last,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [4:0] cfg_data,
  output int         errors,
  output int         outstanding
);
  import attu_pkg::*;

  logic [4:0]  alpha_used;
  int unsigned n_states;
  int unsigned n_trans;
  logic        have_start;
  logic [4:0]  start_id;
  logic [1:0]  marks [STATE_SLOTS];   // bit0 initial, bit1 accepting
  int          heads [PAIR_TOTAL];
  int          t_dest [TRANS_TOTAL];
  int          t_link [TRANS_TOTAL];
  res_t        awaited [$];
  int          fail_tally = 0;

  function automatic res_t res_word(logic st, logic [4:0] sid, logic acc, logic fin);
    res_t w;
    w.status = st;
    w.state  = sid;
    w.acc    = acc;
    w.last   = fin;
    return w;
  endfunction

  task automatic clear_table();
    n_states   = 0;
    have_start = 1'b0;
    start_id   = '0;
    n_trans    = 0;
    foreach (heads[i]) heads[i] = TRANS_TOTAL;
  endtask

  task automatic table_command(input logic [2:0] cmd, input logic m_init, m_acc,
                               input logic [4:0] sid, src, input logic [3:0] sym,
                               input logic [4:0] dst, mc);
    int pair;
    int tid;
    int limit;
    int hits [$];
    case (cmd)
      CMD_CLEAR: begin
        clear_table();
        awaited.push_back(RES_OK);
      end
      CMD_ADD_STATE: begin
        if (n_states >= STATE_SLOTS) begin
          awaited.push_back(RES_FAIL);
        end else begin
          marks[n_states] = {m_acc, m_init};
          if (m_init && !have_start) begin
            have_start = 1'b1;
            start_id   = 5'(n_states);
          end
          awaited.push_back(res_word(1'b0, 5'(n_states), 1'b0, 1'b1));
          n_states++;
        end
      end
      CMD_SET_INIT: begin
        if (sid >= n_states) begin
          awaited.push_back(RES_FAIL);
        end else begin
          have_start    = 1'b1;
          start_id      = sid;
          marks[sid][0] = 1'b1;
          awaited.push_back(RES_OK);
        end
      end
      CMD_ADD_TRANS: begin
        if (src >= n_states || dst >= n_states || sym >= alpha_used ||
            n_trans >= TRANS_TOTAL) begin
          awaited.push_back(RES_FAIL);
        end else begin
          pair            = src * ALPHABET_MAX + sym;
          t_dest[n_trans] = dst;
          t_link[n_trans] = heads[pair];
          heads[pair]     = n_trans;
          n_trans++;
          awaited.push_back(RES_OK);
        end
      end
      CMD_SUCC: begin
        limit = (mc > MAX_RETURN) ? MAX_RETURN : mc;
        if (src < n_states && sym < alpha_used) begin
          tid = heads[src * ALPHABET_MAX + sym];
          // newest first
          while (tid < TRANS_TOTAL && hits.size() < limit) begin
            hits.push_back(t_dest[tid]);
            tid = t_link[tid];
          end
        end
        if (hits.size() == 0) begin
          awaited.push_back(RES_FAIL);
        end else begin
          foreach (hits[i])
            awaited.push_back(res_word(1'b0, 5'(hits[i]), 1'b0, i == hits.size() - 1));
        end
      end
      CMD_ACCEPT: begin
        if (sid >= n_states) awaited.push_back(RES_FAIL);
        else awaited.push_back(res_word(1'b0, 5'd0, marks[sid][1], 1'b1));
      end
      default: awaited.push_back(RES_FAIL);
    endcase
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      alpha_used = 5'(ALPHABET_MAX);
      clear_table();
      foreach (marks[i]) marks[i] = '0;
      awaited.delete();
    end else begin
      if (pop && !empty) begin
        got = res_word(status, result_state, accept_mark, last);
        if (awaited.size() == 0) begin
          fail_tally++;
          $display("%0t: unexpected result word status=%0d state=%0d acc=%0d last=%0d",
                   $time, got.status, got.state, got.acc, got.last);
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            fail_tally++;
            $display("%0t: result mismatch: expected status=%0d state=%0d acc=%0d last=%0d,",
                     $time, want.status, want.state, want.acc, want.last);
            $display("%0t:   actual status=%0d state=%0d acc=%0d last=%0d",
                     $time, got.status, got.state, got.acc, got.last);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        alpha_used = (cfg_data > ALPHABET_MAX) ? 5'(ALPHABET_MAX) : cfg_data;
      if (push && !full)
        table_command(command, mark_initial, mark_accepting, query_id, source_state,
                      symbol, dest_state, max_count);
    end
    errors      <= fail_tally;
    outstanding <= awaited.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the automaton transition table unit.
// A directed opening walks the rejections, the marks and one short chain,
// then the state slots are filled to capacity, and random phases under
// several alphabet sizes follow. Checking lives in attu_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import attu_pkg::*;

  localparam int PHASE_ITEMS = 50;    // random words per alphabet setting
  localparam int LONG_HOLD   = 300;   // cycles the result side stays off
  localparam int FILL_TRANS  = 40;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [2:0] command = CMD_CLEAR;
  logic       mark_initial = 1'b0;
  logic       mark_accepting = 1'b0;
  logic [4:0] query_id = '0;
  logic [4:0] source_state = '0;
  logic [3:0] symbol = '0;
  logic [4:0] dest_state = '0;
  logic [4:0] max_count = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic       status;
  logic [4:0] result_state;
  logic       accept_mark;
  logic       last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = '0;
  int         errors;
  int         outstanding;

  // stimulus bookkeeping: how many states exist, how many symbols are legal
  int states_made = 0;
  int alpha_lim   = ALPHABET_MAX;
  bit gaps_on     = 1'b1;   // random idling on both sides
  bit hold_req    = 1'b0;   // asks the result side for one long hold-off

  automaton_transition_table_unit uut (.*);

  attu_checker chk (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result side: pop most of the time, with random idle bursts, and one long
  // hold-off on request so the command queue backs up and full rises.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one command word and hold it until taken. push is left high so the
  // next word can follow back to back; an idle burst lowers it.
  task automatic send_word(input logic [2:0] cmd, input logic mi, ma,
                           input logic [4:0] sid, src, input logic [3:0] sy,
                           input logic [4:0] dst, mc);
    push           <= 1'b1;
    command        <= cmd;
    mark_initial   <= mi;
    mark_accepting <= ma;
    query_id       <= sid;
    source_state   <= src;
    symbol         <= sy;
    dest_state     <= dst;
    max_count      <= mc;
    do @(posedge clk); while (full);
    // track the state count the same way the table does
    if (cmd == CMD_CLEAR) states_made = 0;
    else if (cmd == CMD_ADD_STATE && states_made < STATE_SLOTS) states_made++;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every awaited result word has come back.
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Alphabet write; only called with the unit drained.
  task automatic write_alpha(input logic [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    alpha_lim = (v > ALPHABET_MAX) ? ALPHABET_MAX : v;
  endtask

  // Half the picks land on the first few states / symbols so chains get long.
  function automatic logic [4:0] pick_state();
    int span;
    span = (states_made < 3) ? states_made : 3;
    if (states_made == 0) return 5'($urandom_range(0, 31));
    if ($urandom_range(0, 1)) return 5'($urandom_range(0, span - 1));
    return 5'($urandom_range(0, states_made - 1));
  endfunction

  function automatic logic [3:0] pick_symbol();
    int span;
    span = (alpha_lim < 2) ? alpha_lim : 2;
    if (alpha_lim == 0) return 4'($urandom_range(0, 15));
    if ($urandom_range(0, 1)) return 4'($urandom_range(0, span - 1));
    return 4'($urandom_range(0, alpha_lim - 1));
  endfunction

  // Mostly well-formed commands on live states; a slice of every kind keeps
  // raw random operands, and a few words are pure noise (unused codes too).
  task automatic send_random();
    logic [2:0] cmd;
    logic       mi;
    logic       ma;
    logic [4:0] sid;
    logic [4:0] src;
    logic [3:0] sy;
    logic [4:0] dst;
    logic [4:0] mc;
    int         pick;
    cmd  = 3'($urandom_range(0, 7));
    mi   = 1'($urandom);
    ma   = 1'($urandom);
    sid  = 5'($urandom);
    src  = 5'($urandom);
    sy   = 4'($urandom);
    dst  = 5'($urandom);
    mc   = 5'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      cmd = CMD_CLEAR;
    end else if (pick < 8) begin
      // noise: keep everything as drawn
    end else if (pick < 22) begin
      cmd = CMD_ADD_STATE;
    end else if (pick < 27) begin
      cmd = CMD_SET_INIT;
      if (states_made > 0 && pick >= 24) sid = 5'($urandom_range(0, states_made - 1));
    end else if (pick < 57) begin
      cmd = CMD_ADD_TRANS;
      if (pick >= 30) begin
        src = pick_state();
        dst = pick_state();
        sy  = pick_symbol();
      end
    end else if (pick < 87) begin
      cmd = CMD_SUCC;
      if (pick >= 60) begin
        src = pick_state();
        sy  = pick_symbol();
      end
      if ($urandom_range(0, 3) != 0) mc = 5'($urandom_range(0, 6));
    end else begin
      cmd = CMD_ACCEPT;
      if (states_made > 0 && pick >= 90) sid = 5'($urandom_range(0, states_made - 1));
    end
    send_word(cmd, mi, ma, sid, src, sy, dst, mc);
  endtask

  initial begin
    logic [4:0] plan [6];
    logic [4:0] v;
    plan = '{5'd0, 5'd1, 5'd7, 5'd17, 5'd16, 5'd16};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // --- directed opening, alphabet at its reset value of 16 ---
    // empty table: every operand is unknown
    send_word(CMD_SUCC,     1'b0, 1'b0, 5'd0,  5'd0,  4'd0,  5'd0,  5'd5);
    send_word(CMD_ACCEPT,   1'b0, 1'b0, 5'd0,  5'd0,  4'd0,  5'd0,  5'd0);
    send_word(CMD_SET_INIT, 1'b0, 1'b0, 5'd31, 5'd0,  4'd0,  5'd0,  5'd0);
    send_word(CMD_ADD_TRANS, 1'b0, 1'b0, 5'd0, 5'd0,  4'd0,  5'd0,  5'd0);
    // unused command codes, all other fields at their top
    send_word(3'd6, 1'b1, 1'b1, 5'd31, 5'd31, 4'd15, 5'd31, 5'd31);
    send_word(3'd7, 1'b1, 1'b1, 5'd31, 5'd31, 4'd15, 5'd31, 5'd31);
    // three states: accepting only, first initial (becomes start), both
    send_word(CMD_ADD_STATE, 1'b0, 1'b1, 5'd0, 5'd0,  4'd0,  5'd0,  5'd0);
    send_word(CMD_ADD_STATE, 1'b1, 1'b0, 5'd0, 5'd0,  4'd0,  5'd0,  5'd0);
    send_word(CMD_ADD_STATE, 1'b1, 1'b1, 5'd0, 5'd0,  4'd0,  5'd0,  5'd0);
    send_word(CMD_SET_INIT, 1'b0, 1'b0, 5'd2,  5'd0,  4'd0,  5'd0,  5'd0);
    send_word(CMD_ACCEPT,   1'b0, 1'b0, 5'd0,  5'd0,  4'd0,  5'd0,  5'd0);
    send_word(CMD_ACCEPT,   1'b0, 1'b0, 5'd1,  5'd0,  4'd0,  5'd0,  5'd0);
    send_word(CMD_ACCEPT,   1'b0, 1'b0, 5'd3,  5'd0,  4'd0,  5'd0,  5'd0);
    // unknown destination, then a three-long chain on the top symbol
    send_word(CMD_ADD_TRANS, 1'b0, 1'b0, 5'd0, 5'd0,  4'd15, 5'd3,  5'd0);
    send_word(CMD_ADD_TRANS, 1'b0, 1'b0, 5'd0, 5'd0,  4'd15, 5'd1,  5'd0);
    send_word(CMD_ADD_TRANS, 1'b0, 1'b0, 5'd0, 5'd0,  4'd15, 5'd2,  5'd0);
    send_word(CMD_ADD_TRANS, 1'b0, 1'b0, 5'd0, 5'd0,  4'd15, 5'd0,  5'd0);
    // count above the cap, zero count, a count of one
    send_word(CMD_SUCC,     1'b0, 1'b0, 5'd0,  5'd0,  4'd15, 5'd0,  5'd31);
    send_word(CMD_SUCC,     1'b0, 1'b0, 5'd0,  5'd0,  4'd15, 5'd0,  5'd0);
    send_word(CMD_SUCC,     1'b0, 1'b0, 5'd0,  5'd0,  4'd15, 5'd0,  5'd1);
    // empty chain, unknown source
    send_word(CMD_SUCC,     1'b0, 1'b0, 5'd0,  5'd2,  4'd15, 5'd0,  5'd16);
    send_word(CMD_SUCC,     1'b0, 1'b0, 5'd0,  5'd31, 4'd0,  5'd0,  5'd16);
    // clear drops states and chains alike
    send_word(CMD_CLEAR,    1'b0, 1'b0, 5'd0,  5'd0,  4'd0,  5'd0,  5'd0);
    send_word(CMD_SUCC,     1'b0, 1'b0, 5'd0,  5'd0,  4'd15, 5'd0,  5'd16);
    send_word(CMD_ACCEPT,   1'b0, 1'b0, 5'd0,  5'd0,  4'd0,  5'd0,  5'd0);

    // --- fill: all state slots plus one, then a batch of transitions ---
    settle();
    write_alpha(5'd31);   // above the maximum, capped to 16
    repeat (STATE_SLOTS + 1)
      send_word(CMD_ADD_STATE, 1'($urandom), 1'($urandom), 5'd0, 5'd0, 4'd0, 5'd0, 5'd0);
    repeat (FILL_TRANS)
      send_word(CMD_ADD_TRANS, 1'b0, 1'b0, 5'd0, pick_state(), pick_symbol(),
                pick_state(), 5'd0);
    repeat (10)
      send_word(CMD_SUCC, 1'b0, 1'b0, 5'd0, pick_state(), pick_symbol(), 5'd0,
                5'($urandom_range(14, 31)));
    send_word(CMD_ACCEPT, 1'b0, 1'b0, 5'd31, 5'd0, 4'd0, 5'd0, 5'd0);

    // --- random phases, one alphabet setting each ---
    // The third phase carries the long result-side hold-off; the last runs
    // without idling on either side.
    for (int p = 0; p < 6; p++) begin
      settle();
      v = (p == 4) ? 5'($urandom_range(2, 15)) : plan[p];
      write_alpha(v);
      if (p == 0)
        send_word(CMD_CLEAR, 1'b0, 1'b0, 5'd0, 5'd0, 4'd0, 5'd0, 5'd0);
      if (p == 2) hold_req = 1'b1;
      if (p == 5) gaps_on = 1'b0;
      repeat (PHASE_ITEMS) send_random();
    end

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
hdl/attu_pkg.sv
hdl/attu_front.sv
hdl/attu_back.sv
hdl/automaton_transition_table_unit.sv
hdl/attu_checker.sv
test/attu_checker.sv
test/tb_top.sv
